@@ rtl/core/atcp_pkg.sv @@
// Shared types, constants and helper functions of the ANSI text console parser.
`timescale 1ns / 1ps
`default_nettype none
package atcp_pkg;

  // Default sizes, handed to the top level as parameter defaults.
  localparam int unsigned MaxColumns = 256;
  localparam int unsigned MaxRows    = 128;
  localparam int unsigned SeqChars   = 32;
  localparam int unsigned MaxParams  = 16;

  // Register reset values and fixed field constants.
  localparam logic [8:0]  ColumnsReset = 9'd80;
  localparam logic [7:0]  RowsReset    = 8'd25;
  localparam logic [7:0]  AttrReset    = 8'h0F;
  localparam logic [7:0]  AttrDefault  = 8'h07;
  localparam int unsigned ParamW       = 15;
  localparam logic [14:0] ParamSat     = 15'h7FFF;
  localparam logic [15:0] BlankGlyph   = 16'h0020;
  localparam logic [15:0] AsciiLast    = 16'h007F;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW    = 2;
  localparam logic [1:0]  RegColumns = 2'd0;
  localparam logic [1:0]  RegRows    = 2'd1;

  // Control characters.
  localparam logic [7:0] ChBs  = 8'h08;
  localparam logic [7:0] ChHt  = 8'h09;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChVt  = 8'h0B;
  localparam logic [7:0] ChCr  = 8'h0D;
  localparam logic [7:0] ChEsc = 8'h1B;

  // Sequence characters.
  localparam logic [7:0] ChLbr  = 8'h5B;
  localparam logic [7:0] ChSemi = 8'h3B;
  localparam logic [7:0] Ch0    = 8'h30;
  localparam logic [7:0] Ch9    = 8'h39;
  localparam logic [7:0] FinIch = 8'h40;
  localparam logic [7:0] FinCuu = 8'h41;
  localparam logic [7:0] FinCud = 8'h42;
  localparam logic [7:0] FinCuf = 8'h43;
  localparam logic [7:0] FinCub = 8'h44;
  localparam logic [7:0] FinCnl = 8'h45;
  localparam logic [7:0] FinCpl = 8'h46;
  localparam logic [7:0] FinCha = 8'h47;
  localparam logic [7:0] FinCup = 8'h48;
  localparam logic [7:0] FinEd  = 8'h4A;
  localparam logic [7:0] FinEl  = 8'h4B;
  localparam logic [7:0] FinIl  = 8'h4C;
  localparam logic [7:0] FinDl  = 8'h4D;
  localparam logic [7:0] FinDch = 8'h50;
  localparam logic [7:0] FinEch = 8'h58;
  localparam logic [7:0] FinHpr = 8'h61;
  localparam logic [7:0] FinVpa = 8'h64;
  localparam logic [7:0] FinVpr = 8'h65;
  localparam logic [7:0] FinHvp = 8'h66;
  localparam logic [7:0] FinScp = 8'h73;
  localparam logic [7:0] FinRcp = 8'h75;
  localparam logic [7:0] FinSgr = 8'h6D;

  // Command kinds on the result channel.
  typedef enum logic [1:0] {
    KIND_PUT    = 2'd0,
    KIND_BLANK  = 2'd1,
    KIND_SCROLL = 2'd2
  } kind_e;

  // Pending action of one item.
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_GLYPH,
    ACT_RUN
  } act_e;

  // Escape parse stage.
  typedef enum logic [1:0] {
    ESC_TEXT,
    ESC_START,
    ESC_PARAMS,
    ESC_POISON
  } esc_e;

  // Digit group mode.
  typedef enum logic [1:0] {
    TOK_IDLE,
    TOK_DIGITS,
    TOK_DROP
  } tok_e;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_EXEC,
    S_SGR_RD,
    S_SGR_EX,
    S_FORM,
    S_TAIL,
    S_OUT_A,
    S_OUT_S,
    S_CRUN,
    S_OUT_C
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic exec;
    logic sgr_rd;
    logic sgr_ex;
    logic form;
    logic clear;
    logic tail;
    logic push_slot;
    logic push_scroll;
    logic last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic early;
    logic sgr_start;
    logic sgr_done;
    logic slot_valid;
    logic tail;
    logic out_free;
  } status_t;

  // SGR color palette, normal and bright rows.
  function automatic logic [3:0] sgr_color(input logic bright, input logic [2:0] idx);
    logic [3:0] c;
    unique case (idx)
      3'd0: c = 4'h0;
      3'd1: c = 4'h4;
      3'd2: c = 4'h2;
      3'd3: c = 4'h6;
      3'd4: c = 4'h1;
      3'd5: c = 4'h5;
      3'd6: c = 4'h3;
      default: c = 4'h7;
    endcase
    return {bright, c[2:0]};
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/atcp_ram.sv @@
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module atcp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ rtl/core/atcp_ctrl.sv @@
// Controller state machine that sequences one transaction through the datapath.
`timescale 1ns / 1ps
`default_nettype none
module atcp_ctrl #(
  parameter int unsigned CELL_W = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire atcp_pkg::status_t  st_i,
  output atcp_pkg::cmd_t          cmd_o
);

  localparam int unsigned CntW = $clog2(CELL_W + 1);

  atcp_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  div_cnt_q, div_cnt_d;

  // State and remainder step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= atcp_pkg::S_IDLE;
      div_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      div_cnt_q <= div_cnt_d;
    end
  end

  // Next state.
  always_comb begin
    state_d   = state_q;
    div_cnt_d = div_cnt_q;
    unique case (state_q)
      atcp_pkg::S_IDLE: begin
        if (in_valid_i) state_d = atcp_pkg::S_PREP;
      end
      atcp_pkg::S_PREP: begin
        div_cnt_d = '0;
        state_d   = st_i.early ? atcp_pkg::S_IDLE : atcp_pkg::S_DIV;
      end
      atcp_pkg::S_DIV: begin
        div_cnt_d = div_cnt_q + CntW'(1);
        if (div_cnt_q == CntW'(CELL_W - 1)) state_d = atcp_pkg::S_EXEC;
      end
      atcp_pkg::S_EXEC: begin
        state_d = st_i.sgr_start ? atcp_pkg::S_SGR_RD : atcp_pkg::S_FORM;
      end
      atcp_pkg::S_SGR_RD: state_d = atcp_pkg::S_SGR_EX;
      atcp_pkg::S_SGR_EX: begin
        state_d = st_i.sgr_done ? atcp_pkg::S_FORM : atcp_pkg::S_SGR_RD;
      end
      atcp_pkg::S_FORM: state_d = atcp_pkg::S_TAIL;
      atcp_pkg::S_TAIL: state_d = atcp_pkg::S_OUT_A;
      atcp_pkg::S_OUT_A: begin
        if (!st_i.slot_valid || st_i.out_free) begin
          state_d = st_i.tail ? atcp_pkg::S_OUT_S : atcp_pkg::S_IDLE;
        end
      end
      atcp_pkg::S_OUT_S: begin
        if (st_i.out_free) state_d = atcp_pkg::S_CRUN;
      end
      atcp_pkg::S_CRUN: state_d = atcp_pkg::S_OUT_C;
      atcp_pkg::S_OUT_C: begin
        if (st_i.out_free) state_d = atcp_pkg::S_IDLE;
      end
      default: state_d = atcp_pkg::S_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      atcp_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      atcp_pkg::S_PREP:   cmd_o.prep     = 1'b1;
      atcp_pkg::S_DIV:    cmd_o.div_step = 1'b1;
      atcp_pkg::S_EXEC:   cmd_o.exec     = 1'b1;
      atcp_pkg::S_SGR_RD: cmd_o.sgr_rd   = 1'b1;
      atcp_pkg::S_SGR_EX: cmd_o.sgr_ex   = 1'b1;
      atcp_pkg::S_FORM: begin
        cmd_o.form  = 1'b1;
        cmd_o.clear = 1'b1;
      end
      atcp_pkg::S_TAIL: cmd_o.tail = 1'b1;
      atcp_pkg::S_OUT_A: begin
        cmd_o.push_slot = st_i.slot_valid && st_i.out_free;
        cmd_o.last      = !st_i.tail;
      end
      atcp_pkg::S_OUT_S: cmd_o.push_scroll = st_i.out_free;
      atcp_pkg::S_CRUN:  cmd_o.form        = 1'b1;
      atcp_pkg::S_OUT_C: begin
        cmd_o.push_slot = st_i.out_free;
        cmd_o.last      = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

  // A result is never pushed over one that is still waiting.
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.push_slot || cmd_o.push_scroll) |-> st_i.out_free)
    else $error("result pushed while output register busy");

  // An accepted transaction always starts its preparation step.
  a_accept_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == atcp_pkg::S_PREP))
    else $error("accepted transaction did not enter preparation");

  // The remainder loop stays within the dividend width.
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == atcp_pkg::S_DIV) |-> (div_cnt_q < CntW'(CELL_W)))
    else $error("remainder step count out of range");

  // A scroll is always followed by its blank row.
  a_scroll_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push_scroll |=> (state_q == atcp_pkg::S_CRUN))
    else $error("scroll not followed by blank row");

endmodule
`default_nettype wire

@@ rtl/core/atcp_dp.sv @@
// Datapath: configuration, cursor, parser state, arithmetic and result register.
`timescale 1ns / 1ps
`default_nettype none
module atcp_dp #(
  parameter int unsigned MAX_COLUMNS = atcp_pkg::MaxColumns,
  parameter int unsigned MAX_ROWS    = atcp_pkg::MaxRows,
  parameter int unsigned SEQ_CHARS   = atcp_pkg::SeqChars,
  parameter int unsigned MAX_PARAMS  = atcp_pkg::MaxParams
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  input  wire logic [atcp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [8:0]                     cfg_data_i,
  input  wire logic [15:0]                    code_point_i,
  input  wire atcp_pkg::cmd_t                 cmd_i,
  output atcp_pkg::status_t                   st_o,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [1:0]                          command_kind_o,
  output logic [15:0]                         cell_position_o,
  output logic [15:0]                         cell_count_o,
  output logic [7:0]                          cell_style_o,
  output logic [15:0]                         glyph_o,
  output logic                                last_command_o
);

  localparam int unsigned ColW  = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned RowW  = $clog2(MAX_ROWS + 1);
  localparam int unsigned CellW = $clog2(MAX_COLUMNS * MAX_ROWS + 1);
  localparam int unsigned AW    = atcp_pkg::ParamW + ColW + 3;
  localparam int unsigned BufW  = $clog2(SEQ_CHARS);
  localparam int unsigned TotW  = $clog2(MAX_PARAMS + 1);
  localparam int unsigned IdxW  = $clog2(MAX_PARAMS);
  localparam int unsigned PW    = atcp_pkg::ParamW;

  // Clamp a signed position into 0..lim.
  function automatic logic signed [AW-1:0] clamp_cell(input logic signed [AW-1:0] val,
                                                      input logic signed [AW-1:0] lim);
    logic signed [AW-1:0] r;
    if (val[AW-1]) r = '0;
    else if (val > lim) r = lim;
    else r = val;
    return r;
  endfunction

  // Configuration and control state.
  logic [8:0]            columns_q;
  logic [7:0]            rows_q;
  logic [CellW-1:0]      cursor_q, saved_q;
  atcp_pkg::esc_e        stage_q;
  logic [TotW-1:0]       total_q;
  logic [BufW-1:0]       buf_q;
  logic [1:0]            field_q;
  atcp_pkg::tok_e        tok_q;
  logic                  first_q, second_q;
  logic [7:0]            attr_q;
  logic                  bright_q;
  logic                  out_valid_q;

  // Item payload and working registers.
  logic [15:0]           code_q;
  logic [ColW-1:0]       w_q;
  logic [CellW-1:0]      n_q;
  logic signed [AW-1:0]  yw_q;
  logic [ColW-1:0]       rem_q;
  logic [CellW-1:0]      dvd_q;
  logic [PW-1:0]         cur_q, y0_q, y1_q;
  atcp_pkg::act_e        act_q;
  logic signed [AW-1:0]  lo_q, hi_q, p_q;
  logic [15:0]           glyph_q;
  logic                  fin_q, tail_q;
  logic [TotW-1:0]       sgr_idx_q;
  logic                  slot_valid_q;
  atcp_pkg::kind_e       slot_kind_q;
  logic [15:0]           slot_pos_q, slot_cnt_q, slot_glyph_q;
  logic [1:0]            out_kind_q;
  logic [15:0]           out_pos_q, out_cnt_q, out_glyph_q;
  logic [7:0]            out_style_q;
  logic                  out_last_q;

  // Clamped geometry and current parameter values.
  logic [ColW-1:0]       w_c;
  logic [RowW-1:0]       h_c;
  logic [7:0]            v;
  logic [PW-1:0]         y_c, x_c;
  logic [ColW-1:0]       col;

  assign v   = code_q[7:0];
  assign col = rem_q;
  assign y_c = first_q ? y0_q : '0;
  assign x_c = (first_q && second_q) ? y1_q : '0;

  always_comb begin
    if (columns_q == 9'd0) w_c = ColW'(1);
    else if (32'(columns_q) > MAX_COLUMNS) w_c = ColW'(MAX_COLUMNS);
    else w_c = ColW'(columns_q);
    if (rows_q == 8'd0) h_c = RowW'(1);
    else if (32'(rows_q) > MAX_ROWS) h_c = RowW'(MAX_ROWS);
    else h_c = RowW'(rows_q);
  end

  // Signed views of the working values.
  logic signed [AW-1:0] ps, ys, xs, ws, ns, cs, ss;
  assign ps = AW'(cursor_q);
  assign ys = AW'(y_c);
  assign xs = AW'(x_c);
  assign ws = AW'(w_q);
  assign ns = AW'(n_q);
  assign cs = AW'(col);
  assign ss = AW'(saved_q);

  // One restoring remainder step.
  logic [ColW:0] r2;
  assign r2 = {rem_q, dvd_q[CellW-1]};

  // Parameter store.
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  logic [PW-1:0]   ram_wdata;
  logic [PW-1:0]   ram_rdata;

  atcp_ram #(
    .Width(PW),
    .Depth(MAX_PARAMS)
  ) u_params (
    .clk_i  (clk_i),
    .we_i   (ram_we && cmd_i.exec),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.sgr_rd),
    .raddr_i(sgr_idx_q[IdxW-1:0]),
    .rdata_o(ram_rdata)
  );

  // Effect of one item: cursor move, pending glyph or run, parser updates.
  atcp_pkg::act_e       e_act;
  logic signed [AW-1:0] e_lo, e_hi, e_p;
  logic [15:0]          e_glyph;
  atcp_pkg::esc_e       e_stage;
  logic                 e_fin, e_sgr, e_saved_we;
  logic [BufW-1:0]      n_buf;
  logic [1:0]           n_field;
  atcp_pkg::tok_e       n_tok;
  logic [TotW-1:0]      n_total;
  logic                 n_first, n_second;
  logic [PW+3:0]        nv;
  logic                 is_digit;

  always_comb begin
    e_act      = atcp_pkg::ACT_NONE;
    e_lo       = ps;
    e_hi       = ps;
    e_p        = ps;
    e_glyph    = code_q;
    e_stage    = stage_q;
    e_fin      = 1'b0;
    e_sgr      = 1'b0;
    e_saved_we = 1'b0;
    n_buf      = buf_q;
    n_field    = field_q;
    n_tok      = tok_q;
    n_total    = total_q;
    n_first    = first_q;
    n_second   = second_q;
    ram_we     = 1'b0;
    ram_waddr  = total_q[IdxW-1:0];
    ram_wdata  = '0;
    nv         = 5'd10 * cur_q + (PW + 4)'(v[3:0]);
    is_digit   = (v >= atcp_pkg::Ch0) && (v <= atcp_pkg::Ch9);
    if (stage_q == atcp_pkg::ESC_TEXT) begin
      // Plain text and control characters.
      if (code_q > atcp_pkg::AsciiLast) begin
        e_act = atcp_pkg::ACT_GLYPH;
        e_p   = ps + AW'(1);
      end else begin
        unique case (v)
          atcp_pkg::ChLf: e_p = ps + ws - cs;
          atcp_pkg::ChVt: e_p = ps + ws;
          atcp_pkg::ChCr: e_p = ps - cs;
          atcp_pkg::ChHt: e_p = ps + AW'(3'd4 - {1'b0, col[1:0]});
          atcp_pkg::ChBs: begin
            e_p     = ps - AW'(1);
            e_lo    = ps - AW'(1);
            e_act   = atcp_pkg::ACT_GLYPH;
            e_glyph = atcp_pkg::BlankGlyph;
          end
          atcp_pkg::ChEsc: e_stage = atcp_pkg::ESC_START;
          default: begin
            e_act = atcp_pkg::ACT_GLYPH;
            e_p   = ps + AW'(1);
          end
        endcase
      end
    end else if (is_digit || v == atcp_pkg::ChSemi) begin
      // Collect one parameter character.
      if (buf_q < BufW'(SEQ_CHARS - 1)) begin
        n_buf = buf_q + BufW'(1);
        if (v == atcp_pkg::ChSemi) begin
          n_tok = atcp_pkg::TOK_IDLE;
          if (field_q < 2'd2) n_field = field_q + 2'd1;
        end else if (tok_q == atcp_pkg::TOK_IDLE) begin
          if (total_q < TotW'(MAX_PARAMS)) begin
            ram_we    = 1'b1;
            ram_wdata = PW'(v[3:0]);
            n_total   = total_q + TotW'(1);
            n_tok     = atcp_pkg::TOK_DIGITS;
          end else begin
            n_tok = atcp_pkg::TOK_DROP;
          end
          if (field_q == 2'd0) n_first = 1'b1;
          else if (field_q == 2'd1) n_second = 1'b1;
        end else if (tok_q == atcp_pkg::TOK_DIGITS) begin
          ram_we    = 1'b1;
          ram_waddr = IdxW'(total_q - TotW'(1));
          ram_wdata = (nv > (PW + 4)'(atcp_pkg::ParamSat)) ? atcp_pkg::ParamSat : PW'(nv);
        end
      end
    end else begin
      // Final character of a sequence.
      e_fin   = 1'b1;
      e_stage = atcp_pkg::ESC_TEXT;
      e_act   = atcp_pkg::ACT_NONE;
      unique case (v)
        atcp_pkg::FinIch: begin
          e_act = atcp_pkg::ACT_RUN;
          e_hi  = ps + ys;
        end
        atcp_pkg::FinCuu: e_p = ps - yw_q;
        atcp_pkg::FinCud, atcp_pkg::FinVpr: e_p = ps + yw_q;
        atcp_pkg::FinCuf, atcp_pkg::FinHpr: e_p = ps + ys;
        atcp_pkg::FinCub: e_p = ps - ys;
        atcp_pkg::FinCnl: if (y_c != '0) e_p = ps - cs + yw_q;
        atcp_pkg::FinCpl: if (y_c != '0) e_p = ps - cs - yw_q;
        atcp_pkg::FinCha: e_p = ps - cs + ys;
        atcp_pkg::FinCup, atcp_pkg::FinHvp: begin
          e_p = ((y_c != '0) ? (yw_q - ws) : AW'(0)) + ((x_c != '0) ? (xs - AW'(1)) : AW'(0));
        end
        atcp_pkg::FinEd: begin
          e_act = atcp_pkg::ACT_RUN;
          e_lo  = (y_c == PW'(1)) ? ps : AW'(0);
          e_hi  = ns;
        end
        atcp_pkg::FinEl: begin
          if (y_c == PW'(0)) begin
            e_act = atcp_pkg::ACT_RUN;
            e_hi  = ps + ws - cs + AW'(1);
          end else if (y_c == PW'(1)) begin
            e_act = atcp_pkg::ACT_RUN;
            e_lo  = ps - cs;
          end else if (y_c == PW'(2)) begin
            e_act = atcp_pkg::ACT_RUN;
            e_lo  = ps - cs;
            e_hi  = ps - cs + ws;
          end
        end
        atcp_pkg::FinIl: begin
          e_act = atcp_pkg::ACT_RUN;
          e_lo  = ps - cs;
          e_hi  = yw_q - cs;
        end
        atcp_pkg::FinDl: begin
          e_act = atcp_pkg::ACT_RUN;
          e_lo  = yw_q + cs + AW'(1);
          e_hi  = ps + ws - cs + AW'(1);
        end
        atcp_pkg::FinDch: begin
          e_act = atcp_pkg::ACT_RUN;
          e_lo  = ps - ys + AW'(1);
          e_hi  = ps + AW'(1);
          e_p   = ps - ys;
        end
        atcp_pkg::FinEch: begin
          e_act = atcp_pkg::ACT_RUN;
          e_lo  = ps - ys;
        end
        atcp_pkg::FinVpa: e_p = yw_q + cs;
        atcp_pkg::FinScp: e_saved_we = 1'b1;
        atcp_pkg::FinRcp: e_p = ss;
        atcp_pkg::FinSgr: e_sgr = (total_q != '0);
        default: e_p = ps;
      endcase
    end
  end

  // SGR code of one stored parameter.
  logic [7:0]    sgr_attr;
  logic          sgr_bright;
  logic [PW-1:0] x30, x40;
  assign x30 = ram_rdata - PW'(30);
  assign x40 = ram_rdata - PW'(40);

  always_comb begin
    sgr_attr   = attr_q;
    sgr_bright = bright_q;
    if (ram_rdata == PW'(0)) begin
      sgr_attr   = atcp_pkg::AttrDefault;
      sgr_bright = 1'b1;
    end else if (ram_rdata == PW'(2)) begin
      sgr_bright = 1'b0;
    end else if (ram_rdata == PW'(22)) begin
      sgr_bright = 1'b1;
    end else if (ram_rdata >= PW'(30) && ram_rdata <= PW'(37)) begin
      sgr_attr = {attr_q[7:4], atcp_pkg::sgr_color(bright_q, x30[2:0])};
    end else if (ram_rdata >= PW'(40) && ram_rdata <= PW'(47)) begin
      sgr_attr = {atcp_pkg::sgr_color(bright_q, x40[2:0]), attr_q[3:0]};
    end else if (ram_rdata == PW'(38) || ram_rdata == PW'(39)) begin
      sgr_attr = {attr_q[7:4], 4'h7};
    end else if (ram_rdata == PW'(49)) begin
      sgr_attr = {4'h0, attr_q[3:0]};
    end
  end

  // Result slot from the pending action.
  logic signed [AW-1:0] f_a, f_b, f_cnt;
  logic signed [AW-1:0] t_p;
  assign f_a   = clamp_cell(lo_q, ns);
  assign f_b   = clamp_cell(hi_q - AW'(1), ns);
  assign f_cnt = f_b - f_a + AW'(1);
  assign t_p   = (p_q > ns) ? (p_q - ws) : p_q;

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  // Control state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q   <= atcp_pkg::ColumnsReset;
      rows_q      <= atcp_pkg::RowsReset;
      cursor_q    <= '0;
      saved_q     <= '0;
      stage_q     <= atcp_pkg::ESC_TEXT;
      total_q     <= '0;
      buf_q       <= '0;
      field_q     <= '0;
      tok_q       <= atcp_pkg::TOK_IDLE;
      first_q     <= 1'b0;
      second_q    <= 1'b0;
      attr_q      <= atcp_pkg::AttrReset;
      bright_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          atcp_pkg::RegColumns: columns_q <= cfg_data_i;
          atcp_pkg::RegRows:    rows_q    <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (cmd_i.prep && st_o.early) begin
        if (v == atcp_pkg::ChLbr) begin
          if (stage_q != atcp_pkg::ESC_POISON) begin
            stage_q <= atcp_pkg::esc_e'(2'(stage_q) + 2'd1);
          end
        end else begin
          stage_q <= atcp_pkg::ESC_TEXT;
        end
      end
      if (cmd_i.exec) begin
        stage_q  <= e_stage;
        buf_q    <= n_buf;
        field_q  <= n_field;
        tok_q    <= n_tok;
        total_q  <= n_total;
        first_q  <= n_first;
        second_q <= n_second;
        if (e_saved_we) saved_q <= CellW'(clamp_cell(ps, ns));
      end
      if (cmd_i.sgr_ex) begin
        attr_q   <= sgr_attr;
        bright_q <= sgr_bright;
      end
      if (cmd_i.clear && fin_q) begin
        total_q  <= '0;
        buf_q    <= '0;
        field_q  <= '0;
        tok_q    <= atcp_pkg::TOK_IDLE;
        first_q  <= 1'b0;
        second_q <= 1'b0;
      end
      if (cmd_i.tail) cursor_q <= CellW'(clamp_cell(t_p, ns));
      if (cmd_i.push_slot || cmd_i.push_scroll) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Working registers of the item in flight.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) code_q <= code_point_i;
    if (cmd_i.prep) begin
      w_q   <= w_c;
      n_q   <= CellW'(CellW'(w_c) * CellW'(h_c));
      yw_q  <= AW'(y_c) * AW'(w_c);
      rem_q <= '0;
      dvd_q <= cursor_q;
    end
    if (cmd_i.div_step) begin
      rem_q <= (r2 >= {1'b0, w_q}) ? ColW'(r2 - {1'b0, w_q}) : ColW'(r2);
      dvd_q <= {dvd_q[CellW-2:0], 1'b0};
    end
    if (cmd_i.exec) begin
      act_q     <= e_act;
      lo_q      <= e_lo;
      hi_q      <= e_hi;
      p_q       <= e_p;
      glyph_q   <= e_glyph;
      fin_q     <= e_fin;
      sgr_idx_q <= '0;
      if (ram_we) begin
        cur_q <= ram_wdata;
        if (ram_waddr == IdxW'(0)) y0_q <= ram_wdata;
        if (ram_waddr == IdxW'(1)) y1_q <= ram_wdata;
      end
    end
    if (cmd_i.sgr_ex) sgr_idx_q <= sgr_idx_q + TotW'(1);
    if (cmd_i.clear && fin_q) begin
      y0_q <= '0;
      y1_q <= '0;
    end
    if (cmd_i.form) begin
      slot_pos_q <= f_a[15:0];
      if (act_q == atcp_pkg::ACT_GLYPH) begin
        slot_valid_q <= 1'b1;
        slot_kind_q  <= atcp_pkg::KIND_PUT;
        slot_cnt_q   <= 16'd1;
        slot_glyph_q <= glyph_q;
      end else begin
        slot_valid_q <= (act_q == atcp_pkg::ACT_RUN) && (lo_q < hi_q);
        slot_kind_q  <= atcp_pkg::KIND_BLANK;
        slot_cnt_q   <= f_cnt[15:0];
        slot_glyph_q <= atcp_pkg::BlankGlyph;
      end
    end
    if (cmd_i.tail) begin
      tail_q <= p_q > ns;
      p_q    <= t_p;
      lo_q   <= t_p;
      hi_q   <= t_p + ws;
      act_q  <= atcp_pkg::ACT_RUN;
    end
    if (cmd_i.push_slot) begin
      out_kind_q  <= 2'(slot_kind_q);
      out_pos_q   <= slot_pos_q;
      out_cnt_q   <= slot_cnt_q;
      out_glyph_q <= slot_glyph_q;
      out_style_q <= attr_q;
      out_last_q  <= cmd_i.last;
    end else if (cmd_i.push_scroll) begin
      out_kind_q  <= 2'(atcp_pkg::KIND_SCROLL);
      out_pos_q   <= '0;
      out_cnt_q   <= '0;
      out_glyph_q <= '0;
      out_style_q <= attr_q;
      out_last_q  <= 1'b0;
    end
  end

  // Status back to the controller.
  always_comb begin
    st_o.early      = (stage_q != atcp_pkg::ESC_TEXT) &&
                      ((v == atcp_pkg::ChLbr) || (stage_q != atcp_pkg::ESC_PARAMS));
    st_o.sgr_start  = e_sgr;
    st_o.sgr_done   = (sgr_idx_q + TotW'(1)) == total_q;
    st_o.slot_valid = slot_valid_q;
    st_o.tail       = tail_q;
    st_o.out_free   = out_free;
  end

  assign out_valid_o     = out_valid_q;
  assign command_kind_o  = out_kind_q;
  assign cell_position_o = out_pos_q;
  assign cell_count_o    = out_cnt_q;
  assign cell_style_o    = out_style_q;
  assign glyph_o         = out_glyph_q;
  assign last_command_o  = out_last_q;

endmodule
`default_nettype wire

@@ rtl/core/ansi_text_console_parser.sv @@
// The cursor column comes from a restoring remainder unit that takes one dividend bit per
// cycle. An SGR sequence reads and applies each stored parameter in turn; a scroll adds
// a scroll command and a blank row command; escape bytes that only change the parse stage
// skip the remainder unit. The block takes one item at a time; the next item is taken
// while the last result waits. Reset clears the control state and the output valid flag,
// but not the parameter store or the working and result payload registers.
`timescale 1ns / 1ps
`default_nettype none
module ansi_text_console_parser #(
  parameter int unsigned MAX_COLUMNS = atcp_pkg::MaxColumns,
  parameter int unsigned MAX_ROWS    = atcp_pkg::MaxRows,
  parameter int unsigned SEQ_CHARS   = atcp_pkg::SeqChars,
  parameter int unsigned MAX_PARAMS  = atcp_pkg::MaxParams
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [atcp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [8:0]                   cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [15:0]                  code_point_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [1:0]                        command_kind_o,
  output logic [15:0]                       cell_position_o,
  output logic [15:0]                       cell_count_o,
  output logic [7:0]                        cell_style_o,
  output logic [15:0]                       glyph_o,
  output logic                              last_command_o
);

  localparam int unsigned CellW = $clog2(MAX_COLUMNS * MAX_ROWS + 1);

  atcp_pkg::cmd_t    cmd;
  atcp_pkg::status_t st;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Sequencer.
  atcp_ctrl #(
    .CELL_W(CellW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  // Cursor, parser and result datapath.
  atcp_dp #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS),
    .SEQ_CHARS  (SEQ_CHARS),
    .MAX_PARAMS (MAX_PARAMS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .code_point_i   (code_point_i),
    .cmd_i          (cmd),
    .st_o           (st),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .command_kind_o (command_kind_o),
    .cell_position_o(cell_position_o),
    .cell_count_o   (cell_count_o),
    .cell_style_o   (cell_style_o),
    .glyph_o        (glyph_o),
    .last_command_o (last_command_o)
  );

endmodule
`default_nettype wire

@@ test/ansi_text_console_parser_checker.sv @@
// Checker for the ANSI text console parser: predicts drawing commands and compares them.
`timescale 1ns / 1ps
module ansi_text_console_parser_checker
  import atcp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [15:0] code_point_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  command_kind_i,
  input  logic [15:0] cell_position_i,
  input  logic [15:0] cell_count_i,
  input  logic [7:0]  cell_style_i,
  input  logic [15:0] glyph_i,
  input  logic        last_command_i,
  output int          pending_o,
  output int          commands_o,
  output int          fails_o
);

  // SGR parameter codes.
  localparam int SgrReset     = 0;
  localparam int SgrFaint     = 2;
  localparam int SgrNormal    = 22;
  localparam int SgrFgFirst   = 30;
  localparam int SgrFgLast    = 37;
  localparam int SgrFgExt     = 38;
  localparam int SgrFgDefault = 39;
  localparam int SgrBgFirst   = 40;
  localparam int SgrBgLast    = 47;
  localparam int SgrBgDefault = 49;

  typedef struct {
    kind_e       kind;
    logic [15:0] pos;
    logic [15:0] cnt;
    logic [7:0]  style;
    logic [15:0] glyph;
    logic        last;
  } draw_cmd_t;

  logic [3:0] ansi_hue [8] = '{4'h0, 4'h4, 4'h2, 4'h6, 4'h1, 4'h5, 4'h3, 4'h7};

  draw_cmd_t expected_cmds[$];
  draw_cmd_t step_cmds[$];

  // Shadow state of the console.
  int          cols, rws;
  int          cursor, saved_cursor;
  esc_e        stage;
  int          plist [MaxParams];
  int          ptotal, nbuf, fidx;
  tok_e        tmode;
  logic        f1set, f2set;
  logic [7:0]  attr;
  logic        bright;

  function automatic int clampi(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic push_cmd(input kind_e k, input int pos, input int cnt, input logic [15:0] g);
    draw_cmd_t c;
    c.kind  = k;
    c.pos   = pos[15:0];
    c.cnt   = cnt[15:0];
    c.style = attr;
    c.glyph = g;
    c.last  = 1'b0;
    step_cmds.push_back(c);
  endtask

  // Blank the cells lo..hi-1, each end clamped to the screen.
  task automatic blank_cells(input int lo, input int hi, input int n);
    int a, b;
    if (lo >= hi) return;
    a = clampi(lo, 0, n);
    b = clampi(hi - 1, 0, n);
    push_cmd(KIND_BLANK, a, b - a + 1, BlankGlyph);
  endtask

  task automatic clear_params();
    foreach (plist[i]) plist[i] = 0;
    ptotal = 0;
    nbuf   = 0;
    fidx   = 0;
    tmode  = TOK_IDLE;
    f1set  = 1'b0;
    f2set  = 1'b0;
  endtask

  // Collect one digit or separator of a parameter list.
  task automatic take_param_char(input logic [7:0] v);
    int nv;
    if (nbuf >= SeqChars - 1) return;
    nbuf++;
    if (v == ChSemi) begin
      tmode = TOK_IDLE;
      if (fidx < 2) fidx++;
      return;
    end
    if (tmode == TOK_IDLE) begin
      if (ptotal < MaxParams) begin
        plist[ptotal] = 0;
        ptotal++;
        tmode = TOK_DIGITS;
      end else begin
        tmode = TOK_DROP;
      end
      if (fidx == 0) f1set = 1'b1;
      else if (fidx == 1) f2set = 1'b1;
    end
    if (tmode == TOK_DIGITS && ptotal > 0) begin
      nv = plist[ptotal-1] * 10 + (int'(v) - int'(Ch0));
      if (nv > int'(ParamSat)) nv = int'(ParamSat);
      plist[ptotal-1] = nv;
    end
  endtask

  task automatic apply_style();
    int x;
    logic [3:0] hue;
    for (int i = 0; i < ptotal && i < MaxParams; i++) begin
      x = plist[i];
      if (x == SgrReset) begin
        attr   = AttrDefault;
        bright = 1'b1;
      end else if (x == SgrFaint) begin
        bright = 1'b0;
      end else if (x == SgrNormal) begin
        bright = 1'b1;
      end else if (x >= SgrFgFirst && x <= SgrFgLast) begin
        hue  = ansi_hue[x - SgrFgFirst] | {bright, 3'b000};
        attr = {attr[7:4], hue};
      end else if (x >= SgrBgFirst && x <= SgrBgLast) begin
        hue  = ansi_hue[x - SgrBgFirst] | {bright, 3'b000};
        attr = {hue, attr[3:0]};
      end else if (x == SgrFgExt || x == SgrFgDefault) begin
        attr = {attr[7:4], 4'h7};
      end else if (x == SgrBgDefault) begin
        attr = {4'h0, attr[3:0]};
      end
    end
  endtask

  // Execute a sequence final on cursor p.
  task automatic run_final(input logic [7:0] f, inout int p, input int w, input int n);
    int y, col, x;
    y   = f1set ? plist[0] : 0;
    col = p % w;
    case (f)
      FinIch: blank_cells(p, p + y, n);
      FinCuu: p -= y * w;
      FinCud, FinVpr: p += y * w;
      FinCuf, FinHpr: p += y;
      FinCub: p -= y;
      FinCnl: if (y > 0) p = p - col + y * w;
      FinCpl: if (y > 0) p = p - col - y * w;
      FinCha: p = p - col + y;
      FinCup, FinHvp: begin
        x = (f1set && f2set) ? plist[1] : 0;
        p = ((y != 0) ? y - 1 : 0) * w + ((x != 0) ? x - 1 : 0);
      end
      FinEd: begin
        if (y == 1) blank_cells(p, n, n);
        else blank_cells(0, n, n);
      end
      FinEl: begin
        if (y == 0) blank_cells(p, p + (w - col) + 1, n);
        else if (y == 1) blank_cells(p - col, p, n);
        else if (y == 2) blank_cells(p - col, p - col + w, n);
      end
      FinIl: blank_cells(p - col, y * w - col, n);
      FinDl: blank_cells(y * w + col + 1, p + (w - col) + 1, n);
      FinDch: begin
        blank_cells(p - y + 1, p + 1, n);
        p -= y;
      end
      FinEch: blank_cells(p - y, p, n);
      FinVpa: p = w * y + col;
      FinScp: saved_cursor = clampi(p, 0, n);
      FinRcp: p = saved_cursor;
      FinSgr: apply_style();
      default: ;
    endcase
  endtask

  // Work out the commands caused by one code point.
  task automatic predict_code(input logic [15:0] code);
    logic [7:0] v;
    int w, n, p, col;
    logic done;
    v    = code[7:0];
    w    = clampi(cols, 1, MaxColumns);
    n    = w * clampi(rws, 1, MaxRows);
    p    = cursor;
    done = 1'b0;
    step_cmds.delete();
    if (stage != ESC_TEXT) begin
      if (v == ChLbr) begin
        if (stage != ESC_POISON) stage = esc_e'(stage + 1);
        done = 1'b1;
      end else if (stage != ESC_PARAMS) begin
        stage = ESC_TEXT;
        done  = 1'b1;
      end else if ((v >= Ch0 && v <= Ch9) || v == ChSemi) begin
        take_param_char(v);
      end else begin
        run_final(v, p, w, n);
        clear_params();
        stage = ESC_TEXT;
      end
    end else if (code > AsciiLast) begin
      push_cmd(KIND_PUT, clampi(p, 0, n), 1, code);
      p++;
    end else begin
      col = p % w;
      case (v)
        ChLf: p += w - col;
        ChVt: p += w;
        ChCr: p -= col;
        ChHt: p += 4 - (col % 4);
        ChBs: begin
          p--;
          push_cmd(KIND_PUT, clampi(p, 0, n), 1, BlankGlyph);
        end
        ChEsc: stage = ESC_START;
        default: begin
          push_cmd(KIND_PUT, clampi(p, 0, n), 1, code);
          p++;
        end
      endcase
    end
    if (!done) begin
      // Cursor ran off the bottom: scroll and clear the new last row.
      if (p > n) begin
        push_cmd(KIND_SCROLL, 0, 0, 16'h0000);
        p -= w;
        blank_cells(p, p + w, n);
      end
      cursor = clampi(p, 0, n);
    end
    if (step_cmds.size() > 0) step_cmds[step_cmds.size()-1].last = 1'b1;
    foreach (step_cmds[i]) expected_cmds.push_back(step_cmds[i]);
  endtask

  task automatic compare_field(input string name, input int exp, input int got);
    if (exp != got) begin
      $error("%s: expected %0d, got %0d", name, exp, got);
      fails_o++;
    end
  endtask

  // Observe the three channels at every clock edge.
  always @(posedge clk_i or negedge rst_ni) begin
    draw_cmd_t e;
    if (!rst_ni) begin
      cols         = ColumnsReset;
      rws          = RowsReset;
      cursor       = 0;
      saved_cursor = 0;
      stage        = ESC_TEXT;
      attr         = AttrReset;
      bright       = 1'b1;
      clear_params();
      expected_cmds.delete();
      pending_o  <= 0;
      commands_o <= 0;
      fails_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        commands_o <= commands_o + 1;
        if (expected_cmds.size() == 0) begin
          $error("unexpected command transaction: kind %0d position %0d",
                 command_kind_i, cell_position_i);
          fails_o++;
        end else begin
          e = expected_cmds.pop_front();
          compare_field("command_kind", e.kind, command_kind_i);
          compare_field("cell_position", e.pos, cell_position_i);
          compare_field("cell_count", e.cnt, cell_count_i);
          compare_field("cell_style", e.style, cell_style_i);
          compare_field("glyph", e.glyph, glyph_i);
          compare_field("last_command", e.last, last_command_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == RegColumns) cols = cfg_data_i;
        else if (cfg_index_i == RegRows) rws = cfg_data_i[7:0];
      end
      if (in_valid_i && in_ready_i) predict_code(code_point_i);
      pending_o <= expected_cmds.size();
    end
  end

endmodule

@@ test/ansi_text_console_parser_tb.sv @@
// Testbench top of the ANSI text console parser: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module ansi_text_console_parser_tb;
  import atcp_pkg::*;

  localparam int ItemTarget = 410;
  localparam int HoldCycles = 400;
  localparam int SettleCycles = 80;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = RegColumns;
  logic [8:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] code_point = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  command_kind;
  logic [15:0] cell_position, cell_count, glyph;
  logic [7:0]  cell_style;
  logic        last_command;
  int          pending, commands, fails;

  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   n_sent = 0;
  logic hold_go = 1'b0;
  logic hold_seen;
  int   hold_left;

  logic [7:0] finals [21] = '{FinIch, FinCuu, FinCud, FinCuf, FinCub, FinCnl, FinCpl,
                              FinCha, FinCup, FinEd, FinEl, FinIl, FinDl, FinDch,
                              FinEch, FinHpr, FinVpa, FinVpr, FinHvp, FinScp, FinRcp};
  logic [7:0] controls [5] = '{ChBs, ChHt, ChLf, ChVt, ChCr};
  int geo_cols [6] = '{1, 256, 0, 511, 7, 40};
  int geo_rows [6] = '{1, 128, 0, 255, 3, 12};
  int idle_mix [4][2] = '{'{0, 0}, '{73, 0}, '{0, 73}, '{9, 9}};

  ansi_text_console_parser dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .code_point_i   (code_point),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .command_kind_o (command_kind),
    .cell_position_o(cell_position),
    .cell_count_o   (cell_count),
    .cell_style_o   (cell_style),
    .glyph_o        (glyph),
    .last_command_o (last_command)
  );

  ansi_text_console_parser_checker checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .code_point_i   (code_point),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .command_kind_i (command_kind),
    .cell_position_i(cell_position),
    .cell_count_i   (cell_count),
    .cell_style_i   (cell_style),
    .glyph_i        (glyph),
    .last_command_i (last_command),
    .pending_o      (pending),
    .commands_o     (commands),
    .fails_o        (fails)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Receiver: random stalls, plus a long hold-off whenever hold_go toggles.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_seen <= 1'b0;
      hold_left <= 0;
    end else if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one code point and wait for its transaction.
  task automatic send_code(input logic [15:0] cp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    code_point <= cp;
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  task automatic send_number(input int val);
    string s;
    s = $sformatf("%0d", val);
    for (int i = 0; i < s.len(); i++) send_code({8'h00, s[i]});
  endtask

  // Stop offering and wait until every predicted command has been seen.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[8:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // One random burst: half the time a sequence, else text or noise.
  task automatic send_burst();
    int r, ng, k;
    logic [7:0] fin;
    logic is_sgr;
    r = $urandom_range(99);
    if (r < 50) begin
      is_sgr = ($urandom_range(3) == 0);
      fin = is_sgr ? FinSgr :
            ($urandom_range(9) == 0) ? 8'($urandom_range(8'h20, 8'h7E)) :
            finals[$urandom_range(20)];
      ng = ($urandom_range(11) == 0) ? $urandom_range(17, 20) : $urandom_range(0, 2);
      send_code({8'h00, ChEsc});
      send_code({8'h00, ChLbr});
      for (int g = 0; g < ng; g++) begin
        if (g > 0) send_code({8'h00, ChSemi});
        if ($urandom_range(7) != 0) begin
          if (is_sgr) send_number($urandom_range(0, 49));
          else if ($urandom_range(9) == 0) send_number($urandom_range(0, 99999));
          else send_number($urandom_range(0, 12));
        end
      end
      send_code({8'h00, fin});
    end else if (r < 80) begin
      k = $urandom_range(1, 8);
      for (int i = 0; i < k; i++) begin
        r = $urandom_range(99);
        if (r < 60) send_code(16'($urandom_range(16'h20, 16'h7E)));
        else if (r < 85) send_code({8'h00, controls[$urandom_range(4)]});
        else send_code(16'($urandom_range(16'h80, 16'hFFFF)));
      end
    end else begin
      r = $urandom_range(3);
      if (r == 0) begin
        send_code(16'($urandom()));
      end else if (r == 1) begin
        send_code({8'h00, ChEsc});
        send_code(16'($urandom()));
      end else if (r == 2) begin
        send_code({8'h00, ChEsc});
        send_code({8'h00, ChLbr});
        send_code({8'h00, ChLbr});
        send_number($urandom_range(0, 40));
        send_code(16'($urandom_range(0, 16'hFF)));
      end else begin
        send_code(16'($urandom_range(0, 16'h1F)));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_reg(RegColumns, 80);
    write_reg(RegRows, 25);

    // Directed: controls at the edges, wide code points, odd escape paths.
    send_code({8'h00, ChBs});
    send_code(16'h0041);
    send_code(16'hFFFF);
    send_code(16'h0080);
    send_code({8'h00, ChHt});
    send_code({8'h00, ChCr});
    send_code({8'h00, ChLf});
    send_code({8'h00, ChVt});
    send_code({8'h00, ChEsc});
    send_code(16'h0078);
    send_code({8'h00, ChEsc});
    send_code({8'h00, ChLbr});
    send_code({8'h00, ChLbr});
    send_number(5);
    send_code({8'h00, FinSgr});
    send_code({8'h00, ChEsc});
    send_code({8'h00, ChLbr});
    send_number(3);
    send_code({8'h00, ChSemi});
    send_number(4);
    send_code({8'h00, FinCup});
    send_code({8'h00, ChEsc});
    send_code({8'h00, ChLbr});
    send_code({8'h00, FinEd});
    drain();

    // Random phases over several geometries and flow-control mixes.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(RegColumns, geo_cols[ph]);
      write_reg(RegRows, geo_rows[ph]);
      send_idle_pct = idle_mix[ph % 4][0];
      stall_pct     = idle_mix[ph % 4][1];
      if (ph == 2) begin
        // Receiver holds off while the sender keeps offering.
        send_idle_pct = 0;
        hold_go <= ~hold_go;
        for (int i = 0; i < 40; i++) send_code(16'($urandom_range(16'h20, 16'h7E)));
      end
      while (n_sent < 25 + (ph + 1) * (ItemTarget - 25) / 6) send_burst();
      drain();
    end

    $display("Sent %0d code points, checked %0d drawing commands", n_sent, commands);
    $display("over six screen geometries, four flow-control mixes and one long hold-off.");
    if (fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ ansi_text_console_parser.f @@
rtl/core/atcp_pkg.sv
rtl/core/atcp_ram.sv
rtl/core/atcp_ctrl.sv
rtl/core/atcp_dp.sv
rtl/core/ansi_text_console_parser.sv
test/ansi_text_console_parser_checker.sv
test/ansi_text_console_parser_tb.sv
